@@ sv/kvt_pkg.sv @@
// Shared types and constants for the key-value text tokenizer.
// Used by kvt_front, kvt_queue, kvt_back and keyvalue_text_tokenizer.
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int unsigned TOKEN_MAX = 255;
  localparam int unsigned DEPTH_MAX = 255;
  localparam int unsigned TLEN_W    = $clog2(TOKEN_MAX + 2);
  localparam int unsigned DEPTH_W   = $clog2(DEPTH_MAX + 1);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    KIND_KEY_CHAR   = 3'd0,
    KIND_VALUE_CHAR = 3'd1,
    KIND_OPEN       = 3'd2,
    KIND_CLOSE      = 3'd3,
    KIND_PAIR       = 3'd4,
    KIND_KEY_ONLY   = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] chr;
  } event_t;

  // All results of one item share the depth and overflow flag.
  typedef struct packed {
    logic [1:0]      cnt;
    event_t [2:0]    ev;
    logic [7:0]      level;
    logic            ovf;
  } bundle_t;

endpackage

@@ sv/keyvalue_text_tokenizer.sv @@
// Top level of the key-value text tokenizer: front end, bundle queue and
// back end. Depends on kvt_pkg, kvt_front, kvt_queue and kvt_back.
`timescale 1ns / 1ps

// The tokenizer takes one text byte per cycle as long as its four-entry
// result queue has room, and each byte yields zero to three result items.
// The output stage sends one result item per cycle while the receiver is
// ready; bytes that yield nothing are not queued. Each result passes
// through the result queue and then the registered output stage.
module keyvalue_text_tokenizer import kvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_char, [15:8] out_level,
                                      // [16] out_depth_overflow, rest zero
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser    // [2:0] out_kind
);

  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  bundle_t q_in;
  bundle_t q_head;
  kind_e   out_kind;
  logic [7:0] out_char;
  logic [7:0] out_level;
  logic    out_ovf;

  kvt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_end_i   (s_axis_tlast),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_bundle_o (q_in)
  );

  kvt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  kvt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_char_o  (out_char),
    .out_level_o (out_level),
    .out_ovf_o   (out_ovf),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {7'd0, out_ovf, out_level, out_char};

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("Result queue written while full.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && q_empty))
    else $error("Result queue read while empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && m_axis_tuser != KIND_KEY_CHAR && m_axis_tuser != KIND_VALUE_CHAR)
      |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("Structure event carries a nonzero character.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $past(s_axis_tvalid && s_axis_tready && !s_axis_tlast) &&
      $past(s_axis_tdata) == CH_LF |-> u_front.tol_q == 2'd0)
    else $error("Line feed left tokens counted on the line.");
`endif

endmodule

@@ sv/kvt_front.sv @@
// Front end: accepts text bytes, tracks token, line and depth state and
// classifies each byte into a bundle of up to three results. Uses kvt_pkg.
`timescale 1ns / 1ps

module kvt_front import kvt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_end_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output bundle_t       q_bundle_o
);

  logic               act_q, act_d;
  logic               quoted_q, quoted_d;
  logic               comment_q, comment_d;
  logic [7:0]         held_q, held_d;
  logic [TLEN_W-1:0]  tlen_q, tlen_d;
  logic [1:0]         tol_q, tol_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               sat_q, sat_d;
  logic               accept;
  bundle_t            bndl;

  function automatic bundle_t append(bundle_t b, kind_e k, logic [7:0] c);
    bundle_t r;
    r = b;
    if (r.cnt != 2'd3) begin
      r.ev[r.cnt].kind = k;
      r.ev[r.cnt].chr  = c;
      r.cnt            = r.cnt + 2'd1;
    end
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic              is_space;
    logic              is_lsp;
    logic              is_quote;
    logic              fin;
    logic              lend;
    logic              add;
    logic [TLEN_W-1:0] tlen_cur;
    kind_e             kc;

    act_d     = act_q;
    quoted_d  = quoted_q;
    comment_d = comment_q;
    held_d    = held_q;
    tlen_d    = tlen_q;
    tol_d     = tol_q;
    depth_d   = depth_q;
    sat_d     = sat_q;
    bndl      = '0;

    is_space = (in_byte_i == CH_SPACE) || (in_byte_i == CH_TAB);
    is_lsp   = (in_byte_i == CH_LF) || (in_byte_i == CH_VT) ||
               (in_byte_i == CH_FF) || (in_byte_i == CH_CR);
    is_quote = (in_byte_i == CH_QUOTE);
    kc       = (tol_q == 2'd0) ? KIND_KEY_CHAR : KIND_VALUE_CHAR;
    fin      = 1'b0;
    lend     = 1'b0;
    add      = 1'b0;
    tlen_cur = act_q ? tlen_q : '0;

    if (in_end_i) begin
      fin       = act_q;
      comment_d = 1'b0;
      lend      = 1'b1;
    end else if (comment_q) begin
      if (in_byte_i == CH_LF) begin
        comment_d = 1'b0;
        lend      = 1'b1;
      end
    end else if (act_q) begin
      if (is_quote || (is_space && !quoted_q) || is_lsp) begin
        fin  = 1'b1;
        lend = (in_byte_i == CH_LF);
      end else begin
        add = 1'b1;
      end
    end else begin
      if (is_quote) begin
        act_d    = 1'b1;
        quoted_d = 1'b1;
        tlen_d   = '0;
      end else if (is_space || is_lsp) begin
        lend = (in_byte_i == CH_LF);
      end else begin
        act_d    = 1'b1;
        quoted_d = 1'b0;
        add      = 1'b1;
      end
    end

    if (fin) begin
      act_d    = 1'b0;
      quoted_d = 1'b0;
      tlen_d   = '0;
      if (tlen_q == TLEN_W'(1) && held_q == CH_OPEN) begin
        if (depth_q < DEPTH_W'(DEPTH_MAX)) begin
          depth_d = depth_q + DEPTH_W'(1);
        end else begin
          sat_d = 1'b1;
        end
        tol_d = 2'd0;
        bndl  = append(bndl, KIND_OPEN, 8'h00);
      end else if (tlen_q == TLEN_W'(1) && held_q == CH_CLOSE) begin
        if (depth_q != '0) begin
          depth_d = depth_q - DEPTH_W'(1);
          tol_d   = 2'd0;
          bndl    = append(bndl, KIND_CLOSE, 8'h00);
        end
      end else if (tlen_q != '0) begin
        if (tlen_q == TLEN_W'(1)) begin
          bndl = append(bndl, kc, held_q);
        end
        if (tol_q == 2'd0) begin
          tol_d = 2'd1;
        end else begin
          tol_d = 2'd2;
          bndl  = append(bndl, KIND_PAIR, 8'h00);
        end
      end
    end

    if (lend) begin
      if (tol_d == 2'd1) begin
        bndl = append(bndl, KIND_KEY_ONLY, 8'h00);
      end
      tol_d = 2'd0;
    end

    if (add) begin
      if (tlen_cur == '0) begin
        held_d = in_byte_i;
        tlen_d = TLEN_W'(1);
      end else if (tlen_cur == TLEN_W'(1)) begin
        if (held_q == CH_SLASH && in_byte_i == CH_SLASH) begin
          act_d     = 1'b0;
          quoted_d  = 1'b0;
          tlen_d    = '0;
          comment_d = 1'b1;
        end else begin
          bndl = append(bndl, kc, held_q);
          if (TOKEN_MAX > 1) begin
            bndl = append(bndl, kc, in_byte_i);
          end
          tlen_d = TLEN_W'(2);
        end
      end else begin
        if (tlen_cur < TLEN_W'(TOKEN_MAX)) begin
          bndl = append(bndl, kc, in_byte_i);
        end
        if (tlen_cur < TLEN_W'(TOKEN_MAX + 1)) begin
          tlen_d = tlen_cur + TLEN_W'(1);
        end
      end
    end

    bndl.level = 8'(depth_d);
    bndl.ovf   = sat_d;
  end

  assign q_push_o   = accept && (bndl.cnt != 2'd0);
  assign q_bundle_o = bndl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      quoted_q  <= 1'b0;
      comment_q <= 1'b0;
      held_q    <= '0;
      tlen_q    <= '0;
      tol_q     <= '0;
      depth_q   <= '0;
      sat_q     <= 1'b0;
    end else if (accept) begin
      act_q     <= act_d;
      quoted_q  <= quoted_d;
      comment_q <= comment_d;
      held_q    <= held_d;
      tlen_q    <= tlen_d;
      tol_q     <= tol_d;
      depth_q   <= depth_d;
      sat_q     <= sat_d;
    end
  end

endmodule

@@ sv/kvt_queue.sv @@
// Short queue of result bundles between the front and back ends.
// Uses bundle_t and the queue sizes from kvt_pkg.
`timescale 1ns / 1ps

module kvt_queue import kvt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output bundle_t head_o,
  output logic    empty_o,
  output logic    full_o
);

  bundle_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q;
  logic [QPTR_W-1:0]  rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

@@ sv/kvt_back.sv @@
// Back end: walks the results of the bundle at the queue head, one per cycle
// unless stalled, into a registered output stage. Uses bundle_t and kind_e from kvt_pkg.
`timescale 1ns / 1ps

module kvt_back import kvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bundle_t    head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output kind_e      out_kind_o,
  output logic [7:0] out_char_o,
  output logic [7:0] out_level_o,
  output logic       out_ovf_o,
  output logic       out_last_o
);

  logic       vld_q;
  logic [1:0] idx_q;
  kind_e      kind_q;
  logic [7:0] char_q;
  logic [7:0] level_q;
  logic       ovf_q;
  logic       last_q;
  logic       advance;
  logic       take;
  logic       is_last;

  assign advance = !vld_q || out_ready_i;
  assign take    = advance && !empty_i;
  assign is_last = ((idx_q + 2'd1) == head_i.cnt);
  assign pop_o   = take && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (advance) begin
      vld_q <= !empty_i;
      if (take) begin
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q  <= head_i.ev[idx_q].kind;
      char_q  <= head_i.ev[idx_q].chr;
      level_q <= head_i.level;
      ovf_q   <= head_i.ovf;
      last_q  <= is_last;
    end
  end

  assign out_valid_o = vld_q;
  assign out_kind_o  = kind_q;
  assign out_char_o  = char_q;
  assign out_level_o = level_q;
  assign out_ovf_o   = ovf_q;
  assign out_last_o  = last_q;

endmodule
